[hw/rtl/nale_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// nale_pkg
// Shared constants, widths and types of the NLMS adaptive line enhancer.
// ============================================================================
package nale_pkg;

    localparam int TAPS  = 40;
    localparam int DELAY = 50;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int ENERGY_W = 38;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 8;

    localparam int DA_W  = (DELAY > 1) ? $clog2(DELAY) : 1;
    localparam int TA_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CLR_N = (DELAY > TAPS) ? DELAY : TAPS;
    localparam int CLR_W = $clog2(CLR_N + 1);

    // Products of a weight and a tap are 40 bits; the sum grows with the tap count.
    localparam int PROD_W = 56;
    localparam int ACC_W  = WEIGHT_W + SAMPLE_W + TA_W + 1;

    localparam int QUOT_W    = 40;
    localparam int DVD_W     = 56;
    localparam int DEN_W     = ENERGY_W + 1;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGULARIZER = 8'd1;

    localparam logic [CFG_W-1:0] STEP_SIZE_RST   = 16'd1966;
    localparam logic [CFG_W-1:0] REGULARIZER_RST = 16'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hw/rtl/nale_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// nale_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module nale_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/nale_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// nale_div
// Restoring unsigned divider, one quotient bit per cycle, saturated result.
// ============================================================================
module nale_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [nale_pkg::DVD_W-1:0]     dividend,
    input  logic [nale_pkg::DEN_W-1:0]     divisor,
    output logic [nale_pkg::QUOT_W-1:0]    quotient,
    output nale_pkg::div_status_t          status
);
    import nale_pkg::*;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= dividend;
                den_reg  <= divisor;
                quo_reg  <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                // The remainder stays below the divisor, so it fits in DEN_W bits.
                if (fits)
                begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = (|quo_reg[DVD_W-1:QUOT_W-1]) ? {1'b0, {(QUOT_W-1){1'b1}}}
                                                    : quo_reg[QUOT_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/nlms_adaptive_line_enhancer_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// nlms_adaptive_line_enhancer_top
// NLMS adaptive line enhancer with delay, tap and weight lines held in RAM.
// ============================================================================
// Usage: a sample transaction on in_valid/in_ready/sample yields exactly one
// prediction transaction on out_valid/out_ready/prediction. Configuration
// writes arrive on cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the step size and index 1 the regularizer, other indexes are ignored.
// A sample runs, when the receiver keeps up, through one multiply-accumulate
// pass over the tap and weight RAMs, a 56-step restoring divide, and a weight
// update pass through the same multiplier. The prediction is registered as
// the divide starts, and the next sample is taken once the weight pass has
// ended.
// After reset a clearing pass zeroes all three RAMs; in_ready stays low during
// it while configuration writes are taken. If the receiver stalls, the
// prediction waits in the output register and the block holds before the
// divide until that register is free.
// ============================================================================
module nlms_adaptive_line_enhancer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [nale_pkg::SAMPLE_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [nale_pkg::SAMPLE_W-1:0] prediction,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nale_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nale_pkg::CFG_W-1:0]        cfg_data
);
    import nale_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR     = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_SHIFT     = 11'b000_0000_0100,
        S_ENERGY    = 11'b000_0000_1000,
        S_MAC       = 11'b000_0001_0000,
        S_MAC_DRAIN = 11'b000_0010_0000,
        S_PRED      = 11'b000_0100_0000,
        S_DIV       = 11'b000_1000_0000,
        S_UPD       = 11'b001_0000_0000,
        S_UPD_DRAIN = 11'b010_0000_0000,
        S_SPARE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]    step_size_reg;
    logic [CFG_W-1:0]    regularizer_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [DA_W-1:0]     dptr_reg;
    logic [TA_W-1:0]     tptr_reg;
    logic [TA_W-1:0]     tw_reg;
    logic [TA_W-1:0]     ta_reg;
    logic [TA_W-1:0]     idx_reg;
    logic [TA_W-1:0]     i1_reg;
    logic [TA_W-1:0]     i2_reg;
    logic                p1_reg;
    logic                p2_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] leave_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [WEIGHT_W-1:0] w2_reg;
    logic signed [QUOT_W-1:0]   q_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] pred_reg;

    // RAM ports
    logic                dly_we;
    logic [DA_W-1:0]     dly_waddr;
    logic [SAMPLE_W-1:0] dly_wdata;
    logic [SAMPLE_W-1:0] dly_rdata;
    logic                tap_we;
    logic [TA_W-1:0]     tap_waddr;
    logic [SAMPLE_W-1:0] tap_wdata;
    logic [TA_W-1:0]     tap_raddr;
    logic [SAMPLE_W-1:0] tap_rdata;
    logic                wt_we;
    logic [TA_W-1:0]     wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata;
    logic [WEIGHT_W-1:0] wt_rdata;

    // Datapath
    logic                       upd_mode;
    logic signed [QUOT_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic signed [ACC_W:0]      acc_rnd;
    logic signed [ACC_W-22:0]   acc_sh;
    logic signed [SAMPLE_W-1:0] pred_c;
    logic signed [SAMPLE_W:0]   err_c;
    logic signed [SAMPLE_W+CFG_W+1:0] sprod_c;
    logic [SAMPLE_W+CFG_W+1:0]  mag_c;
    logic [DEN_W-1:0]           den_sum;
    logic [DEN_W-1:0]           den_c;
    logic signed [PROD_W:0]     dw_rnd;
    logic signed [PROD_W-18:0]  dw;
    logic signed [PROD_W-17:0]  nw;
    logic signed [WEIGHT_W-1:0] nw_sat;
    logic                       issue;
    logic                       out_free;
    logic                       div_start;
    logic [QUOT_W-1:0]          div_q;
    div_status_t                div_st;
    logic [TA_W-1:0]            ta_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign prediction = pred_reg;

    assign upd_mode = (state_reg == S_UPD) || (state_reg == S_UPD_DRAIN);
    assign issue    = (state_reg == S_MAC) || (state_reg == S_UPD);
    assign out_free = !out_valid_reg || out_ready;
    assign div_start = (state_reg == S_PRED) && out_free;
    assign ta_dec   = (ta_reg == '0) ? TA_W'(TAPS - 1) : ta_reg - 1'b1;

    // Shared multiplier: weight times tap, or step quotient times tap.
    assign mul_a = upd_mode ? q_reg : QUOT_W'(signed'(wt_rdata));
    assign mul_p = mul_a * signed'(tap_rdata);

    assign sq = (state_reg == S_SHIFT) ? signed'(dly_rdata) * signed'(dly_rdata)
                                       : leave_reg * leave_reg;

    // Prediction: round half up at bit 22, then saturate.
    assign acc_rnd = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(signed'(23'sd2097152));
    assign acc_sh  = acc_rnd[ACC_W:22];

    always_comb
    begin
        if (acc_sh > (ACC_W - 21)'(32767))
        begin
            pred_c = 16'sh7FFF;
        end
        else if (acc_sh < -(ACC_W - 21)'(32768))
        begin
            pred_c = -16'sh8000;
        end
        else
        begin
            pred_c = acc_sh[SAMPLE_W-1:0];
        end
    end

    assign err_c   = (SAMPLE_W + 1)'(x_reg) - (SAMPLE_W + 1)'(pred_c);
    assign sprod_c = signed'({2'b00, step_size_reg}) * (SAMPLE_W + CFG_W + 2)'(err_c);
    assign mag_c   = sprod_c[SAMPLE_W+CFG_W+1] ? (SAMPLE_W + CFG_W + 2)'(-sprod_c)
                                               : sprod_c;
    assign den_sum = DEN_W'(energy_reg) + DEN_W'(regularizer_reg);
    assign den_c   = (den_sum == '0) ? DEN_W'(1) : den_sum;

    // Weight increment: round half up at bit 18, then saturate the new weight.
    assign dw_rnd = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(19'sd131072);
    assign dw     = dw_rnd[PROD_W:18];
    assign nw     = (PROD_W - 16)'(w2_reg) + (PROD_W - 16)'(dw);

    always_comb
    begin
        if (nw > (PROD_W - 16)'(8388607))
        begin
            nw_sat = 24'sh7FFFFF;
        end
        else if (nw < -(PROD_W - 16)'(8388608))
        begin
            nw_sat = -24'sh800000;
        end
        else
        begin
            nw_sat = nw[WEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        dly_we    = 1'b0;
        dly_waddr = dptr_reg;
        dly_wdata = x_reg;
        tap_we    = 1'b0;
        tap_waddr = tptr_reg;
        tap_wdata = dly_rdata;
        wt_we     = 1'b0;
        wt_waddr  = i2_reg;
        wt_wdata  = nw_sat;
        if (state_reg == S_CLEAR)
        begin
            dly_we    = (clr_reg < CLR_W'(DELAY));
            dly_waddr = clr_reg[DA_W-1:0];
            dly_wdata = '0;
            tap_we    = (clr_reg < CLR_W'(TAPS));
            tap_waddr = clr_reg[TA_W-1:0];
            tap_wdata = '0;
            wt_we     = tap_we;
            wt_waddr  = clr_reg[TA_W-1:0];
            wt_wdata  = '0;
        end
        else if (state_reg == S_SHIFT)
        begin
            dly_we = 1'b1;
            tap_we = 1'b1;
        end
        else if (upd_mode && p2_reg)
        begin
            wt_we = 1'b1;
        end
    end

    assign tap_raddr = issue ? ta_reg : tptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            step_size_reg   <= STEP_SIZE_RST;
            regularizer_reg <= REGULARIZER_RST;
            energy_reg      <= '0;
            dptr_reg        <= '0;
            tptr_reg        <= '0;
            tw_reg          <= '0;
            ta_reg          <= '0;
            idx_reg         <= '0;
            i1_reg          <= '0;
            i2_reg          <= '0;
            p1_reg          <= 1'b0;
            p2_reg          <= 1'b0;
            clr_reg         <= '0;
            x_reg           <= '0;
            leave_reg       <= '0;
            acc_reg         <= '0;
            prod_reg        <= '0;
            w2_reg          <= '0;
            q_reg           <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            pred_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_STEP_SIZE:   step_size_reg   <= cfg_data;
                    REG_REGULARIZER: regularizer_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (div_start)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Read pipeline shared by both passes over the taps.
            p1_reg <= issue;
            i1_reg <= idx_reg;
            p2_reg <= p1_reg;
            if (p1_reg)
            begin
                prod_reg <= mul_p;
                w2_reg   <= signed'(wt_rdata);
                i2_reg   <= i1_reg;
            end
            if (p2_reg && !upd_mode)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
                ta_reg  <= ta_dec;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(CLR_N - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg     <= sample;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    // Delay output enters the tap line over its oldest entry.
                    leave_reg  <= signed'(tap_rdata);
                    energy_reg <= energy_reg + ENERGY_W'(unsigned'(sq));
                    tw_reg     <= tptr_reg;
                    ta_reg     <= tptr_reg;
                    idx_reg    <= '0;
                    acc_reg    <= '0;
                    dptr_reg   <= (dptr_reg == DA_W'(DELAY - 1)) ? '0 : dptr_reg + 1'b1;
                    tptr_reg   <= (tptr_reg == TA_W'(TAPS - 1)) ? '0 : tptr_reg + 1'b1;
                    state_reg  <= S_ENERGY;
                end
                S_ENERGY:
                begin
                    energy_reg <= energy_reg - ENERGY_W'(unsigned'(sq));
                    state_reg  <= S_MAC;
                end
                S_MAC:
                begin
                    if (idx_reg == TA_W'(TAPS - 1))
                    begin
                        state_reg <= S_MAC_DRAIN;
                    end
                end
                S_MAC_DRAIN:
                begin
                    if (!p1_reg && !p2_reg)
                    begin
                        state_reg <= S_PRED;
                    end
                end
                S_PRED:
                begin
                    if (out_free)
                    begin
                        pred_reg      <= pred_c;
                        neg_reg       <= sprod_c[SAMPLE_W+CFG_W+1];
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        q_reg     <= neg_reg ? -signed'(div_q) : signed'(div_q);
                        ta_reg    <= tw_reg;
                        idx_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (idx_reg == TA_W'(TAPS - 1))
                    begin
                        state_reg <= S_UPD_DRAIN;
                    end
                end
                S_UPD_DRAIN:
                begin
                    if (!p1_reg && !p2_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    nale_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY)) u_dly_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dptr_reg),
        .rdata (dly_rdata)
    );

    nale_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    nale_ram #(.WIDTH(WEIGHT_W), .DEPTH(TAPS)) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (idx_reg),
        .rdata (wt_rdata)
    );

    nale_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag_c[31:0], 24'd0}),
        .divisor  (den_c),
        .quotient (div_q),
        .status   (div_st)
    );

`ifndef ASSERT_OFF
    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!p1_reg && !p2_reg && !div_st.busy))
        else $error("sample taken while the tap pipeline or divider is busy");

    a_out_from_pred: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PRED))
        else $error("prediction raised outside the prediction step");

    a_dptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        dptr_reg <= DA_W'(DELAY - 1))
        else $error("delay pointer out of range");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide step");
`endif

endmodule
